>>> sv/vad_hysteresis_segmenter_core_assert.svh
// Assertion macros shared by the segmenter RTL.
`ifndef VAD_HYSTERESIS_SEGMENTER_CORE_ASSERT_SVH
`define VAD_HYSTERESIS_SEGMENTER_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define VHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VHS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/vhs_pkg.sv
`timescale 1ns / 1ps

package vhs_pkg;

    localparam int CHUNK_INDEX_BITS_DEF = 24;
    localparam int RUN_BITS             = 16;
    localparam int CFG_FIELD_BITS       = 16;
    localparam int TOTAL_BITS           = 24;
    localparam int SAMPLE_BITS          = 40;
    localparam int CFG_INDEX_BITS       = 3;
    localparam int CFG_DATA_BITS        = 24;

    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

    localparam logic [CFG_FIELD_BITS-1:0] MIN_SPEECH_RST    = 16'd2;
    localparam logic [CFG_FIELD_BITS-1:0] MIN_SILENCE_RST   = 16'd1;
    localparam logic [CFG_FIELD_BITS-1:0] PAD_RST           = 16'd0;
    localparam logic [CFG_FIELD_BITS-1:0] CHUNK_SAMPLES_RST = 16'd1600;
    localparam logic [TOTAL_BITS-1:0]     TOTAL_RST         = 24'hFFFFFF;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIN_SPEECH    = 3'd0,
        CFG_MIN_SILENCE   = 3'd1,
        CFG_PAD           = 3'd2,
        CFG_CHUNK_SAMPLES = 3'd3,
        CFG_TOTAL         = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_FIELD_BITS-1:0] min_speech;
        logic [CFG_FIELD_BITS-1:0] min_silence;
        logic [CFG_FIELD_BITS-1:0] pad;
        logic [CFG_FIELD_BITS-1:0] chunk_samples;
        logic [TOTAL_BITS-1:0]     total;
    } t_cfg;

endpackage

>>> sv/vhs_tracker.sv
`timescale 1ns / 1ps

module vhs_tracker #(
    parameter int CHUNK_INDEX_BITS = vhs_pkg::CHUNK_INDEX_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_is_speech,
    input  logic                              i_last_chunk,
    input  vhs_pkg::t_cfg                     i_cfg,
    output logic                              o_emit,
    output logic [CHUNK_INDEX_BITS-1:0]       o_start_chunk,
    output logic [vhs_pkg::TOTAL_BITS-1:0]    o_end_chunk
);

    localparam int SW = CHUNK_INDEX_BITS + vhs_pkg::CFG_FIELD_BITS + 1;

    logic                              r_spk, n_spk;
    logic [vhs_pkg::RUN_BITS-1:0]      r_run, n_run;
    logic [CHUNK_INDEX_BITS-1:0]       r_ost, n_ost;
    logic [CHUNK_INDEX_BITS-1:0]       r_lv,  n_lv;
    logic [CHUNK_INDEX_BITS-1:0]       r_idx, n_idx;

    logic                              a_spk;
    logic [vhs_pkg::RUN_BITS-1:0]      a_run;
    logic [CHUNK_INDEX_BITS-1:0]       a_ost;
    logic [CHUNK_INDEX_BITS-1:0]       a_lv;
    logic [vhs_pkg::RUN_BITS-1:0]      run_inc;
    logic                              close;
    logic [SW-1:0]                     end_sum;
    logic [SW-1:0]                     ost_ext;
    logic [SW-1:0]                     pad_ext;

    assign run_inc = (r_run == vhs_pkg::RUN_MAX) ? r_run : r_run + 1'b1;

    always_comb begin
        a_spk = r_spk;
        a_run = r_run;
        a_ost = r_ost;
        a_lv  = r_lv;
        close = 1'b0;
        if (!r_spk) begin
            if (i_is_speech) begin
                if (r_run == '0) begin
                    a_ost = r_idx;
                end
                a_run = run_inc;
                if (run_inc >= i_cfg.min_speech) begin
                    a_spk = 1'b1;
                    a_lv  = r_idx;
                end
            end else begin
                a_run = '0;
                a_ost = '0;
            end
        end else begin
            if (i_is_speech) begin
                a_lv  = r_idx;
                a_run = '0;
            end else begin
                a_run = run_inc;
                if (run_inc >= i_cfg.min_silence) begin
                    close = 1'b1;
                end
            end
        end
    end

    assign o_emit = close | (i_last_chunk & a_spk);

    assign ost_ext = SW'(a_ost);
    assign pad_ext = SW'(i_cfg.pad);
    assign end_sum = SW'(a_lv) + SW'(1) + pad_ext;

    always_comb begin
        if (ost_ext >= pad_ext) begin
            o_start_chunk = CHUNK_INDEX_BITS'(ost_ext - pad_ext);
        end else begin
            o_start_chunk = '0;
        end
        if (end_sum > SW'(i_cfg.total)) begin
            o_end_chunk = i_cfg.total;
        end else begin
            o_end_chunk = vhs_pkg::TOTAL_BITS'(end_sum);
        end
    end

    always_comb begin
        n_spk = a_spk;
        n_run = a_run;
        n_ost = a_ost;
        n_lv  = a_lv;
        n_idx = (r_idx == {CHUNK_INDEX_BITS{1'b1}}) ? r_idx : r_idx + 1'b1;
        if (close) begin
            n_spk = 1'b0;
            n_run = '0;
            n_ost = '0;
        end
        if (i_last_chunk) begin
            n_spk = 1'b0;
            n_run = '0;
            n_ost = '0;
            n_lv  = '0;
            n_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spk <= 1'b0;
            r_run <= '0;
            r_ost <= '0;
            r_lv  <= '0;
            r_idx <= '0;
        end else if (i_accept) begin
            r_spk <= n_spk;
            r_run <= n_run;
            r_ost <= n_ost;
            r_lv  <= n_lv;
            r_idx <= n_idx;
        end
    end

endmodule

>>> sv/vad_hysteresis_segmenter_core.sv
`timescale 1ns / 1ps

// Voice activity segmenter: takes one speech flag per chunk, one item per clock
// when both sides keep up, and returns a padded, clamped segment in sample
// units each time a segment closes on silence or is flushed by last_chunk. A
// result is registered after the run-counter and clamp logic and again after
// the chunk-to-sample multiply (chunk index times chunk_samples). Registers
// are written at any time through the config port, which is always ready, but
// must only change while no item is in flight. There is no clearing pass after
// reset.
module vad_hysteresis_segmenter_core #(
    parameter int CHUNK_INDEX_BITS = vhs_pkg::CHUNK_INDEX_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_is_speech,
    input  logic                                i_last_chunk,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [vhs_pkg::SAMPLE_BITS-1:0]     o_start_sample,
    output logic [vhs_pkg::SAMPLE_BITS-1:0]     o_end_sample,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vhs_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [vhs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    `include "vad_hysteresis_segmenter_core_assert.svh"

    localparam int PW = CHUNK_INDEX_BITS + vhs_pkg::CFG_FIELD_BITS;
    localparam int EW = vhs_pkg::TOTAL_BITS + vhs_pkg::CFG_FIELD_BITS;

    vhs_pkg::t_cfg                      r_cfg;
    logic                               accept;
    logic                               s1_free;
    logic                               s2_free;
    logic                               emit;
    logic [CHUNK_INDEX_BITS-1:0]        start_chunk;
    logic [vhs_pkg::TOTAL_BITS-1:0]     end_chunk;

    logic                               r_s1_vld;
    logic [CHUNK_INDEX_BITS-1:0]        r_s1_start;
    logic [vhs_pkg::TOTAL_BITS-1:0]     r_s1_end;
    logic                               r_out_vld;
    logic [vhs_pkg::SAMPLE_BITS-1:0]    r_start;
    logic [vhs_pkg::SAMPLE_BITS-1:0]    r_end;
    logic [PW-1:0]                      start_prod;
    logic [EW-1:0]                      end_prod;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_speech    <= vhs_pkg::MIN_SPEECH_RST;
            r_cfg.min_silence   <= vhs_pkg::MIN_SILENCE_RST;
            r_cfg.pad           <= vhs_pkg::PAD_RST;
            r_cfg.chunk_samples <= vhs_pkg::CHUNK_SAMPLES_RST;
            r_cfg.total         <= vhs_pkg::TOTAL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (vhs_pkg::t_cfg_idx'(i_cfg_index))
                vhs_pkg::CFG_MIN_SPEECH: begin
                    r_cfg.min_speech <= i_cfg_data[vhs_pkg::CFG_FIELD_BITS-1:0];
                end
                vhs_pkg::CFG_MIN_SILENCE: begin
                    r_cfg.min_silence <= i_cfg_data[vhs_pkg::CFG_FIELD_BITS-1:0];
                end
                vhs_pkg::CFG_PAD: begin
                    r_cfg.pad <= i_cfg_data[vhs_pkg::CFG_FIELD_BITS-1:0];
                end
                vhs_pkg::CFG_CHUNK_SAMPLES: begin
                    r_cfg.chunk_samples <= i_cfg_data[vhs_pkg::CFG_FIELD_BITS-1:0];
                end
                vhs_pkg::CFG_TOTAL: begin
                    r_cfg.total <= i_cfg_data[vhs_pkg::TOTAL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s2_free    = !r_out_vld || !i_out_stall;
    assign s1_free    = !r_s1_vld || s2_free;
    assign o_in_stall = !s1_free;
    assign accept     = i_in_valid && s1_free;

    vhs_tracker #(
        .CHUNK_INDEX_BITS (CHUNK_INDEX_BITS)
    ) u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_is_speech   (i_is_speech),
        .i_last_chunk  (i_last_chunk),
        .i_cfg         (r_cfg),
        .o_emit        (emit),
        .o_start_chunk (start_chunk),
        .o_end_chunk   (end_chunk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && accept && emit) begin
            r_s1_start <= start_chunk;
            r_s1_end   <= end_chunk;
        end
    end

    assign start_prod = PW'(r_s1_start) * PW'(r_cfg.chunk_samples);
    assign end_prod   = EW'(r_s1_end) * EW'(r_cfg.chunk_samples);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_vld) begin
            r_start <= vhs_pkg::SAMPLE_BITS'(start_prod);
            r_end   <= vhs_pkg::SAMPLE_BITS'(end_prod);
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_start_sample = r_start;
    assign o_end_sample   = r_end;

    `VHS_ASSERT(a_stall_only_when_full, o_in_stall |-> (r_s1_vld && r_out_vld && i_out_stall), "input stalled with a free stage")
    `VHS_ASSERT(a_s1_advances, (r_s1_vld && s2_free) |=> r_out_vld, "pending segment not moved to output")
    `VHS_ASSERT(a_emit_end_clamped, (accept && emit) |-> (end_chunk <= r_cfg.total), "segment end above total chunks")
    `VHS_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> (!r_out_vld && !r_s1_vld), "pipeline valid after reset")

endmodule
